FILE: rtl/ste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_pkg
// shared types, constants and register codes of the sobel edge block
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned GRAD_W   = 11;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned CNT_W    = 23;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned GAIN_W   = 25;
  localparam int unsigned CFG_W    = 25;
  localparam int unsigned IDX_W    = 2;

  localparam int unsigned SQ_W        = 22;
  localparam int unsigned ROOT_W      = 11;
  localparam int unsigned ISQRT_STEPS = SQ_W / 2;
  localparam int unsigned PROD_W      = ROOT_W + GAIN_W;
  localparam int unsigned SCALE_SHIFT = 8;

  localparam logic [MAG_W-1:0] Q16_ONE = 17'h10000;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [MAG_W-1:0]  THRESH_RST = 17'd6554;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 25'd11634;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [SQ_W-1:0]  value;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

FILE: rtl/ste_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_pix_if / ste_res_if
// valid/ready channels for pixel beats and result beats
// ----------------------------------------------------------------------------
interface ste_pix_if;
  logic                     valid;
  logic                     ready;
  logic [ste_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface ste_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [ste_pkg::GRAD_W-1:0] grad_x;
  logic signed [ste_pkg::GRAD_W-1:0] grad_y;
  logic [ste_pkg::MAG_W-1:0]         mag_q16;
  logic                              edge_res;
  logic [ste_pkg::SUM_W-1:0]         mag_sum;
  logic [ste_pkg::CNT_W-1:0]         edge_count;
  logic                              last;

  modport source (output valid, output grad_x, output grad_y, output mag_q16,
                  output edge_res, output mag_sum, output edge_count, output last,
                  input ready);
  modport sink   (input valid, input grad_x, input grad_y, input mag_q16,
                  input edge_res, input mag_sum, input edge_count, input last,
                  output ready);
endinterface

FILE: rtl/ste_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module ste_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ste_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_isqrt
// floor integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module ste_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  ste_pkg::sqrt_req_t req,
  output ste_pkg::sqrt_rsp_t rsp
);

  localparam int unsigned W    = ste_pkg::SQ_W;
  localparam int unsigned CW   = $clog2(ste_pkg::ISQRT_STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(ste_pkg::ISQRT_STEPS - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  bit_r, bit_nxt;
  logic [W-1:0]  trial;

  assign trial = res_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.value;
      res_nxt  = '0;
      bit_nxt  = W'(1) << (W - 2);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[ste_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/sobel_edge_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// 3x3 sobel edge detector with threshold and running frame statistics
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_ch    in   one gray pixel, raster order
//  out_ch   out  gx, gy, normalized magnitude, edge bit, frame sums, last
//  cfg_*    in   register write: width, height, threshold, gain
//
//  one pixel is taken at a time; a pixel that completes an interior window
//  passes through take, line store read and window, gradient, two squares,
//  the bit-serial square root with its done cycle, scale and the result
//  load before the next pixel is taken; other pixels pass only through take
//  and window; the square root unit is the slowest step
//  line stores are not cleared at reset; rows 0 and 1 only fill them
//  the next pixel is taken while a result still waits in the output register;
//  a second result waits in the last sequencer state until the first is taken
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = ste_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ste_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ste_pix_if.sink                     in_ch,
  ste_res_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [ste_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ste_pkg::CFG_W-1:0]   cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW = ste_pkg::PIX_W;
  localparam int unsigned GW = ste_pkg::GRAD_W;
  localparam int unsigned MW = ste_pkg::MAG_W;

  // one-hot sequencer
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WIN  = 7'b0000010,
    S_GRAD = 7'b0000100,
    S_SQX  = 7'b0001000,
    S_SQY  = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [ste_pkg::SIZE_W-1:0] width_r, height_r;
  logic [MW-1:0]              thresh_r;
  logic [ste_pkg::GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ste_pkg::WIDTH_RST;
      height_r <= ste_pkg::HEIGHT_RST;
      thresh_r <= ste_pkg::THRESH_RST;
      gain_r   <= ste_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (ste_pkg::reg_idx_t'(cfg_index))
        ste_pkg::REG_WIDTH:  width_r  <= cfg_data[ste_pkg::SIZE_W-1:0];
        ste_pkg::REG_HEIGHT: height_r <= cfg_data[ste_pkg::SIZE_W-1:0];
        ste_pkg::REG_THRESH: thresh_r <= cfg_data[MW-1:0];
        ste_pkg::REG_GAIN:   gain_r   <= cfg_data[ste_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size, as last column / last row
  int unsigned w_cl, h_cl;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last;

  always_comb begin
    w_cl = 32'(width_r);
    h_cl = 32'(height_r);
    if (w_cl < 3) w_cl = 3;
    if (w_cl > MAX_WIDTH) w_cl = MAX_WIDTH;
    if (h_cl < 3) h_cl = 3;
    if (h_cl > MAX_HEIGHT) h_cl = MAX_HEIGHT;
  end

  assign col_last = CW'(w_cl - 1);
  assign row_last = RW'(h_cl - 1);

  // scan position and per-pixel flags
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] pix_r;
  logic          end_row, end_frame, emit;
  logic          last_r, last_nxt;

  assign end_row   = (col_r >= col_last);
  assign end_frame = end_row && (row_r >= row_last);
  assign emit      = (row_r >= RW'(2)) && (col_r >= CW'(2));

  // line stores: a holds the row above, b two rows above
  logic          accept;
  logic          ls_we;
  logic [PW-1:0] a_rdata, b_rdata;

  assign accept = in_ch.valid && in_ch.ready;
  assign ls_we  = (state_r == S_WIN);

  ste_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (ls_we),
    .waddr (col_r),
    .wdata (pix_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (a_rdata)
  );

  ste_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (ls_we),
    .waddr (col_r),
    .wdata (a_rdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (b_rdata)
  );

  // 3x3 window, [row][col], col 2 newest
  logic [PW-1:0] win_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (state_r == S_WIN) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= b_rdata;
      win_r[1][2] <= a_rdata;
      win_r[2][2] <= pix_r;
    end
  end

  // gradients, kept wide enough for the raw sums
  logic signed [GW-1:0] gx_r, gy_r;
  logic signed [GW-1:0] gx_nxt, gy_nxt;

  always_comb begin
    gx_nxt = (GW'(win_r[0][2]) + (GW'(win_r[1][2]) << 1) + GW'(win_r[2][2]))
           - (GW'(win_r[0][0]) + (GW'(win_r[1][0]) << 1) + GW'(win_r[2][0]));
    gy_nxt = (GW'(win_r[2][0]) + (GW'(win_r[2][1]) << 1) + GW'(win_r[2][2]))
           - (GW'(win_r[0][0]) + (GW'(win_r[0][1]) << 1) + GW'(win_r[0][2]));
  end

  // squares, two multipliers: gx squared is registered in S_SQX, gy squared summed in S_SQY
  logic signed [2*GW-1:0]     gx2, gy2;
  logic [ste_pkg::SQ_W-2:0]   sqx_r;
  logic [ste_pkg::SQ_W-1:0]   sq_sum;

  assign gx2    = gx_r * gx_r;
  assign gy2    = gy_r * gy_r;
  assign sq_sum = {1'b0, sqx_r} + {1'b0, gy2[ste_pkg::SQ_W-2:0]};

  ste_pkg::sqrt_req_t sqrt_req;
  ste_pkg::sqrt_rsp_t sqrt_rsp;

  assign sqrt_req.start = (state_r == S_SQY);
  assign sqrt_req.value = sq_sum;

  ste_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // scale by gain, then q16 saturation and threshold
  logic [ste_pkg::PROD_W-1:0] prod_r;
  logic [ste_pkg::PROD_W-ste_pkg::SCALE_SHIFT-1:0] mag_raw;
  logic [MW-1:0]               mag;
  logic                        edge_bit;

  assign mag_raw  = prod_r[ste_pkg::PROD_W-1:ste_pkg::SCALE_SHIFT];
  assign mag      = (mag_raw > (ste_pkg::PROD_W-ste_pkg::SCALE_SHIFT)'(ste_pkg::Q16_ONE))
                    ? ste_pkg::Q16_ONE : mag_raw[MW-1:0];
  assign edge_bit = (mag >= thresh_r);

  // frame accumulators
  logic [ste_pkg::SUM_W-1:0] acc_sum_r, acc_sum_nxt, sum_new;
  logic [ste_pkg::CNT_W-1:0] acc_cnt_r, acc_cnt_nxt, cnt_new;

  assign sum_new = acc_sum_r + ste_pkg::SUM_W'(mag);
  assign cnt_new = acc_cnt_r + ste_pkg::CNT_W'(edge_bit);

  // output register
  logic out_free;
  logic out_load;
  logic out_valid_r, out_valid_nxt;

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == S_FIN) && out_free;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    last_nxt    = last_r;
    acc_sum_nxt = acc_sum_r;
    acc_cnt_nxt = acc_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_WIN;
      end
      S_WIN: begin
        last_nxt = end_frame;
        // step the scan position
        if (end_frame) begin
          col_nxt = '0;
          row_nxt = '0;
        end else if (end_row) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
        if (emit) begin
          state_nxt = S_GRAD;
        end else begin
          state_nxt = S_IDLE;
          if (end_frame) begin
            acc_sum_nxt = '0;
            acc_cnt_nxt = '0;
          end
        end
      end
      S_GRAD: state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_ROOT;
      S_ROOT: begin
        if (sqrt_rsp.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (last_r) begin
            acc_sum_nxt = '0;
            acc_cnt_nxt = '0;
          end else begin
            acc_sum_nxt = sum_new;
            acc_cnt_nxt = cnt_new;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      last_r      <= 1'b0;
      acc_sum_r   <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      last_r      <= last_nxt;
      acc_sum_r   <= acc_sum_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  logic signed [GW-1:0] o_gx_r, o_gy_r;
  logic [MW-1:0]        o_mag_r;
  logic                 o_edge_r, o_last_r;
  logic [ste_pkg::SUM_W-1:0] o_sum_r;
  logic [ste_pkg::CNT_W-1:0] o_cnt_r;

  always_ff @(posedge clk) begin
    if (accept) pix_r <= in_ch.pixel;
    if (state_r == S_GRAD) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
    if (state_r == S_SQX) sqx_r <= gx2[ste_pkg::SQ_W-2:0];
    if (state_r == S_ROOT && sqrt_rsp.done) prod_r <= sqrt_rsp.root * gain_r;
    if (out_load) begin
      o_gx_r   <= gx_r;
      o_gy_r   <= gy_r;
      o_mag_r  <= mag;
      o_edge_r <= edge_bit;
      o_sum_r  <= sum_new;
      o_cnt_r  <= cnt_new;
      o_last_r <= last_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.grad_x     = o_gx_r;
  assign out_ch.grad_y     = o_gy_r;
  assign out_ch.mag_q16    = o_mag_r;
  assign out_ch.edge_res   = o_edge_r;
  assign out_ch.mag_sum    = o_sum_r;
  assign out_ch.edge_count = o_cnt_r;
  assign out_ch.last       = o_last_r;

endmodule

FILE: rtl/ste_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_checker
// port-level assertions for the sobel edge block, bound to the top level
// ----------------------------------------------------------------------------
module ste_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ste_pkg::MAG_W-1:0]   mag_q16,
  input logic                        edge_res,
  input logic [ste_pkg::CNT_W-1:0]   edge_count
);

  // a result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  // one pixel at a time: no beat taken in the cycle after one
  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted while previous pixel in flight");

  // magnitude saturates at q16 one
  a_mag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> mag_q16 <= ste_pkg::Q16_ONE)
    else $error("magnitude above q16 one");

  // edge count includes the current edge
  a_cnt_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && edge_res |-> edge_count != '0)
    else $error("edge count misses current edge");

endmodule

bind sobel_edge_threshold ste_checker u_ste_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .mag_q16    (out_ch.mag_q16),
  .edge_res   (out_ch.edge_res),
  .edge_count (out_ch.edge_count)
);

FILE: tb/sv/sobel_edge_threshold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_threshold_tb
// self-checking bench: pixel frames go in through a queue-fed driver, each
// accepted beat is run through a local sobel predictor, and result beats are
// checked field by field against the queue of predicted results
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;

  typedef struct {
    logic signed [ste_pkg::GRAD_W-1:0] gx;
    logic signed [ste_pkg::GRAD_W-1:0] gy;
    logic [ste_pkg::MAG_W-1:0]         mag;
    logic                              edge_bit;
    logic [ste_pkg::SUM_W-1:0]         sum;
    logic [ste_pkg::CNT_W-1:0]         cnt;
    logic                              last;
  } sobel_res_t;

  typedef enum int {
    STYLE_NOISE  = 0,
    STYLE_BINARY = 1,
    STYLE_RAMP   = 2
  } frame_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ste_pkg::IDX_W-1:0] cfg_index = '0;
  logic [ste_pkg::CFG_W-1:0] cfg_data = '0;

  ste_pix_if pix_if ();
  ste_res_if res_if ();

  sobel_edge_threshold u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: register copies, line stores, window, frame position
  // ---------------------------------------------------------------------------
  logic [ste_pkg::SIZE_W-1:0] width_reg  = ste_pkg::WIDTH_RST;
  logic [ste_pkg::SIZE_W-1:0] height_reg = ste_pkg::HEIGHT_RST;
  logic [ste_pkg::MAG_W-1:0]  thresh_reg = ste_pkg::THRESH_RST;
  logic [ste_pkg::GAIN_W-1:0] gain_reg   = ste_pkg::GAIN_RST;

  logic [ste_pkg::PIX_W-1:0] row_above [ste_pkg::MAX_WIDTH_DEF];
  logic [ste_pkg::PIX_W-1:0] row_two_up [ste_pkg::MAX_WIDTH_DEF];
  logic [ste_pkg::PIX_W-1:0] win [3][3] = '{default: '0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [ste_pkg::SUM_W-1:0] mag_total = '0;
  logic [ste_pkg::CNT_W-1:0] edge_total = '0;

  sobel_res_t expected_res[$];
  logic [ste_pkg::PIX_W-1:0] pending_pix[$];
  int errors = 0;
  bit quiet = 1'b0;

  function automatic int unsigned clamp_dim(logic [ste_pkg::SIZE_W-1:0] v,
                                            int unsigned top);
    if (v < 3) return 3;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // floor square root, one result bit per pass from the top down
  function automatic int unsigned floor_root(int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic predict_pixel(input logic [ste_pkg::PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int gx;
    int gy;
    int unsigned root;
    longint unsigned m;
    bit end_row;
    bit end_frame;
    sobel_res_t r;
    w = clamp_dim(width_reg, ste_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, ste_pkg::MAX_HEIGHT_DEF);
    // slide the window left and load the new right column
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = row_two_up[col_pos];
    win[1][2] = row_above[col_pos];
    win[2][2] = px;
    row_two_up[col_pos] = row_above[col_pos];
    row_above[col_pos] = px;
    end_row = (col_pos >= w - 1);
    end_frame = end_row && (row_pos >= h - 1);
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
      gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
      root = floor_root(32'(gx * gx + gy * gy));
      m = (longint'(root) * longint'(gain_reg)) >> ste_pkg::SCALE_SHIFT;
      if (m > ste_pkg::Q16_ONE) m = ste_pkg::Q16_ONE;
      r.gx = gx[ste_pkg::GRAD_W-1:0];
      r.gy = gy[ste_pkg::GRAD_W-1:0];
      r.mag = m[ste_pkg::MAG_W-1:0];
      r.edge_bit = (m >= thresh_reg);
      mag_total = mag_total + ste_pkg::SUM_W'(m[ste_pkg::MAG_W-1:0]);
      edge_total = edge_total + ste_pkg::CNT_W'(r.edge_bit);
      r.sum = mag_total;
      r.cnt = edge_total;
      r.last = end_frame;
      expected_res.push_back(r);
    end
    if (end_frame) begin
      col_pos = 0;
      row_pos = 0;
      mag_total = '0;
      edge_total = '0;
    end else if (end_row) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'h7FF;
    end else begin
      col_pos = (col_pos + 1) & 32'h7FF;
    end
  endtask

  // ---------------------------------------------------------------------------
  // pixel driver: pops the pending queue, idles in random bursts
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  logic nxt_valid;
  logic [ste_pkg::PIX_W-1:0] nxt_pix;

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel <= '0;
      gap_left = 0;
    end else begin
      nxt_valid = pix_if.valid;
      nxt_pix = pix_if.pixel;
      if (pix_if.valid && pix_if.ready) begin
        predict_pixel(pix_if.pixel);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pix.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 6);
          end else begin
            nxt_valid = 1'b1;
            nxt_pix = pending_pix.pop_front();
          end
        end
      end
      pix_if.valid <= nxt_valid;
      pix_if.pixel <= nxt_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  sobel_res_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: result beat with nothing expected (gx %0d gy %0d mag %0d)",
                   $time, res_if.grad_x, res_if.grad_y, res_if.mag_q16);
          errors++;
        end else begin
          want = expected_res.pop_front();
          if (res_if.grad_x !== want.gx) begin
            $display("%0t: grad_x exp %0d act %0d", $time, want.gx, res_if.grad_x);
            errors++;
          end
          if (res_if.grad_y !== want.gy) begin
            $display("%0t: grad_y exp %0d act %0d", $time, want.gy, res_if.grad_y);
            errors++;
          end
          if (res_if.mag_q16 !== want.mag) begin
            $display("%0t: mag_q16 exp %0d act %0d", $time, want.mag, res_if.mag_q16);
            errors++;
          end
          if (res_if.edge_res !== want.edge_bit) begin
            $display("%0t: edge_res exp %0d act %0d", $time, want.edge_bit, res_if.edge_res);
            errors++;
          end
          if (res_if.mag_sum !== want.sum) begin
            $display("%0t: mag_sum exp %0d act %0d", $time, want.sum, res_if.mag_sum);
            errors++;
          end
          if (res_if.edge_count !== want.cnt) begin
            $display("%0t: edge_count exp %0d act %0d", $time, want.cnt, res_if.edge_count);
            errors++;
          end
          if (res_if.last !== want.last) begin
            $display("%0t: last exp %0d act %0d", $time, want.last, res_if.last);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // caller is on a clock edge; the write lands on the next one
  task automatic reg_write(input ste_pkg::reg_idx_t idx,
                           input logic [ste_pkg::CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      ste_pkg::REG_WIDTH:  width_reg = v[ste_pkg::SIZE_W-1:0];
      ste_pkg::REG_HEIGHT: height_reg = v[ste_pkg::SIZE_W-1:0];
      ste_pkg::REG_THRESH: thresh_reg = v[ste_pkg::MAG_W-1:0];
      ste_pkg::REG_GAIN:   gain_reg = v[ste_pkg::GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drained, plus slack for trailing pixels that yield no beat
  task automatic wait_drained();
    wait (pending_pix.size() == 0 && !pix_if.valid && expected_res.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_frame(input logic [ste_pkg::SIZE_W-1:0] w,
                           input logic [ste_pkg::SIZE_W-1:0] h,
                           input logic [ste_pkg::MAG_W-1:0] th,
                           input logic [ste_pkg::GAIN_W-1:0] g);
    wait_drained();
    @(posedge clk);
    reg_write(ste_pkg::REG_WIDTH, ste_pkg::CFG_W'(w));
    reg_write(ste_pkg::REG_HEIGHT, ste_pkg::CFG_W'(h));
    reg_write(ste_pkg::REG_THRESH, ste_pkg::CFG_W'(th));
    reg_write(ste_pkg::REG_GAIN, ste_pkg::CFG_W'(g));
    cfg_we <= 1'b0;
  endtask

  task automatic queue_frame(input frame_style_t style);
    int unsigned w;
    int unsigned h;
    int v;
    w = clamp_dim(width_reg, ste_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, ste_pkg::MAX_HEIGHT_DEF);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        case (style)
          STYLE_NOISE:  v = $urandom_range(0, 255);
          STYLE_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
          default: begin
            v = x * 9 + y * 5 + $urandom_range(0, 12);
            v = v & 255;
          end
        endcase
        pending_pix.push_back(v[ste_pkg::PIX_W-1:0]);
      end
    end
  endtask

  task automatic queue_pixels(input logic [ste_pkg::PIX_W-1:0] p[]);
    foreach (p[i]) pending_pix.push_back(p[i]);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  int rand_items;
  int unsigned w_r;
  int unsigned h_r;
  logic [ste_pkg::MAG_W-1:0] th_r;
  logic [ste_pkg::GAIN_W-1:0] g_r;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3 frames, full gain and zero threshold so everything saturates
    set_frame(12'd3, 12'd3, 17'd0, 25'd16777216);
    queue_pixels('{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255});
    queue_pixels('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    // edge frames at maximum gain: threshold above q16 one never fires
    set_frame(12'd3, 12'd3, 17'h1FFFF, 25'h1FFFFFF);
    queue_pixels('{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0});
    queue_pixels('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
    // sizes below range clamp to 3, zero gain gives zero magnitude
    set_frame(12'd0, 12'd2, 17'd65536, 25'd0);
    queue_frame(STYLE_NOISE);

    // random phases of small frames
    rand_items = 0;
    while (rand_items < 880) begin
      w_r = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 24);
      h_r = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
      case ($urandom_range(0, 3))
        0: th_r = '0;
        1: th_r = 17'd65536;
        default: th_r = ste_pkg::MAG_W'($urandom_range(0, 40000));
      endcase
      g_r = $urandom_range(0, 5) == 0 ? ste_pkg::GAIN_W'($urandom_range(0, 25'h1FFFFFF))
                                      : ste_pkg::GAIN_W'($urandom_range(0, 200000));
      set_frame(ste_pkg::SIZE_W'(w_r), ste_pkg::SIZE_W'(h_r), th_r, g_r);
      quiet = (rand_items > 750) || ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 3)) begin
        if (rand_items < 880) begin
          queue_frame(frame_style_t'($urandom_range(0, 2)));
          rand_items += clamp_dim(ste_pkg::SIZE_W'(w_r), ste_pkg::MAX_WIDTH_DEF)
                      * clamp_dim(ste_pkg::SIZE_W'(h_r), ste_pkg::MAX_HEIGHT_DEF);
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("PASS sobel_edge_threshold");
    end else begin
      $display("FAIL sobel_edge_threshold");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAIL sobel_edge_threshold");
    $finish;
  end

endmodule
